/* rtl/core/mh64_pkg.sv */
// ============================================================================
// mh64_pkg: shared definitions for the Murmur2 64-bit hash unit
// Holds the mixing constants, the controller/datapath command and status
// structures, the multiplier operand select codes and the mixing functions.
// ============================================================================
package mh64_pkg;

   // 64-bit Murmur2 multiplier and shift-mix distance.
   localparam logic [63:0] MIX_MUL   = 64'hC6A4A7935BD1E995;
   localparam int          MIX_SHIFT = 47;

   // Operand sources for the shared constant multiplier.
   typedef enum logic [2:0] {
      OPND_TOTAL         = 3'd0,
      OPND_WORD          = 3'd1,
      OPND_MIX_PROD      = 3'd2,
      OPND_HASH_XOR_PROD = 3'd3,
      OPND_HASH_XOR_TAIL = 3'd4,
      OPND_MIX_HASH      = 3'd5
   } opnd_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         capture;
      logic         mul_start;
      opnd_sel_type opnd_sel;
      logic         hash_init;
      logic         hash_update;
      logic         result_store;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic first;
      logic last;
      logic full;
      logic partial;
      logic mul_done;
      logic rsp_free;
   } dp_status_type;

   // Shift-mix step: v ^ (v >> 47).
   function automatic logic [63:0] shift_mix(input logic [63:0] v);
      return v ^ (v >> MIX_SHIFT);
   endfunction

   // Mask that keeps the low n bytes of a word (n from 0 to 7).
   function automatic logic [63:0] tail_mask(input logic [2:0] n);
      logic [63:0] m;
      m = '0;
      for (int i = 0; i < 8; i++) begin
         if (3'(i) < n) begin
            m[8*i +: 8] = 8'hFF;
         end
      end
      return m;
   endfunction

endpackage

/* rtl/core/mh64_mul.sv */
// ============================================================================
// mh64_mul: iterative multiply by the Murmur2 constant, modulo 2^64
// Forms the low 64 bits of operand * MIX_MUL from three 32x32 partial
// products, one per cycle, through a single shared multiplier.
// ============================================================================
module mh64_mul
   import mh64_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] operand,
   output logic [63:0] product,
   output logic        done
);

   localparam logic [1:0] STEP_LO_LO = 2'd0;
   localparam logic [1:0] STEP_HI_LO = 2'd1;
   localparam logic [1:0] STEP_LO_HI = 2'd2;

   logic [63:0] opnd_ff;
   logic [63:0] opnd_in;
   logic [63:0] acc_ff;
   logic [63:0] acc_in;
   logic [1:0]  step_ff;
   logic [1:0]  step_in;
   logic        busy_ff;
   logic        busy_in;
   logic        done_ff;
   logic        done_in;
   logic [31:0] mul_x;
   logic [31:0] mul_y;
   logic [63:0] pp;

   // Pick the operand halves for this step and form one partial product.
   always_comb begin
      mul_x = (step_ff == STEP_HI_LO) ? opnd_ff[63:32] : opnd_ff[31:0];
      mul_y = (step_ff == STEP_LO_HI) ? MIX_MUL[63:32] : MIX_MUL[31:0];
      pp    = 64'(mul_x) * 64'(mul_y);
   end

   // Step sequencing and accumulation of the partial products.
   always_comb begin
      opnd_in = opnd_ff;
      acc_in  = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         opnd_in = operand;
         step_in = STEP_LO_LO;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (step_ff == STEP_LO_LO) begin
            acc_in = pp;
         end else begin
            acc_in = acc_ff + {pp[31:0], 32'h0};
         end
         if (step_ff == STEP_LO_HI) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + 2'd1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_LO_LO;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Operand and accumulator registers.
   always_ff @(posedge clock) begin
      opnd_ff <= opnd_in;
      acc_ff  <= acc_in;
   end

   assign product = acc_ff;
   assign done    = done_ff;

`ifndef SYNTHESIS
   // A new multiply is never started while one is still in progress.
   a_no_start_when_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("multiply started while busy");

   // The last partial product is followed by exactly one done pulse.
   a_done_after_last_step: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && step_ff == STEP_LO_HI) |=> (done_ff && !busy_ff))
      else $error("multiply did not finish after its last step");
`endif

endmodule

/* rtl/core/mh64_datapath.sv */
// ============================================================================
// mh64_datapath: registers and mixing logic of the Murmur2 64-bit hash unit
// Holds the seed, running hash, captured transaction fields and the result
// register, and feeds the shared constant multiplier.
// ============================================================================
module mh64_datapath
   import mh64_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  logic          csr_wr_en,
   input  logic [63:0]   csr_wr_data,
   input  logic [63:0]   req_data_word,
   input  logic [3:0]    req_valid_bytes,
   input  logic [31:0]   req_total_length,
   input  logic          req_first_word,
   input  logic          req_last_word,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [63:0]   rsp_hash_value
);

   logic [63:0] seed_ff;
   logic [63:0] hash_ff;
   logic [63:0] hash_in;
   logic [63:0] word_ff;
   logic [3:0]  bytes_ff;
   logic [31:0] total_ff;
   logic        first_ff;
   logic        last_ff;
   logic [63:0] result_ff;
   logic [63:0] result_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic        full;
   logic        partial;
   logic        empty_msg;
   logic [63:0] mul_operand;
   logic [63:0] mul_product;
   logic        mul_done;

   // Byte count classes; any count of eight or more is a full word.
   assign full      = bytes_ff[3];
   assign partial   = !bytes_ff[3] && (bytes_ff[2:0] != 3'd0);
   assign empty_msg = first_ff && !full && !partial;

   // Multiplier operand selection.
   always_comb begin
      case (cmd.opnd_sel)
         OPND_TOTAL:         mul_operand = {32'h0, total_ff};
         OPND_WORD:          mul_operand = word_ff;
         OPND_MIX_PROD:      mul_operand = shift_mix(mul_product);
         OPND_HASH_XOR_PROD: mul_operand = hash_ff ^ mul_product;
         OPND_HASH_XOR_TAIL: mul_operand = hash_ff ^ (word_ff & tail_mask(bytes_ff[2:0]));
         OPND_MIX_HASH:      mul_operand = shift_mix(hash_ff);
         default:            mul_operand = '0;
      endcase
   end

   mh64_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .operand (mul_operand),
      .product (mul_product),
      .done    (mul_done)
   );

   // Running hash update.
   always_comb begin
      hash_in = hash_ff;
      if (cmd.hash_init) begin
         hash_in = seed_ff ^ mul_product;
      end else if (cmd.hash_update) begin
         hash_in = mul_product;
      end
   end

   // Result register and its valid flag; an empty message hashes to zero.
   always_comb begin
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.result_store) begin
         result_in    = empty_msg ? 64'h0 : shift_mix(mul_product);
         rsp_valid_in = 1'b1;
      end
   end

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= '0;
         hash_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            seed_ff <= csr_wr_data;
         end
         hash_ff      <= hash_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Captured transaction fields and result payload.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         word_ff  <= req_data_word;
         bytes_ff <= req_valid_bytes;
         total_ff <= req_total_length;
         first_ff <= req_first_word;
         last_ff  <= req_last_word;
      end
      result_ff <= result_in;
   end

   always_comb begin
      status.first    = first_ff;
      status.last     = last_ff;
      status.full     = full;
      status.partial  = partial;
      status.mul_done = mul_done;
      status.rsp_free = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = result_ff;

`ifndef SYNTHESIS
   // A waiting result is never overwritten before it is taken.
   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.result_store |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while still pending");
`endif

endmodule

/* rtl/core/mh64_ctrl.sv */
// ============================================================================
// mh64_ctrl: sequencing state machine of the Murmur2 64-bit hash unit
// Steps each transaction through initialization, word mixing and
// finalization, issuing one constant multiply at a time to the datapath.
// ============================================================================
module mh64_ctrl
   import mh64_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   typedef enum logic [9:0] {
      ST_IDLE      = 10'b00_0000_0001,
      ST_DISPATCH  = 10'b00_0000_0010,
      ST_WAIT_INIT = 10'b00_0000_0100,
      ST_BODY      = 10'b00_0000_1000,
      ST_WAIT_W1   = 10'b00_0001_0000,
      ST_WAIT_W2   = 10'b00_0010_0000,
      ST_WAIT_H    = 10'b00_0100_0000,
      ST_FINAL     = 10'b00_1000_0000,
      ST_WAIT_F    = 10'b01_0000_0000,
      ST_STORE     = 10'b10_0000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and command decode.
   always_comb begin
      state_in         = state_ff;
      cmd.capture      = 1'b0;
      cmd.mul_start    = 1'b0;
      cmd.opnd_sel     = OPND_TOTAL;
      cmd.hash_init    = 1'b0;
      cmd.hash_update  = 1'b0;
      cmd.result_store = 1'b0;
      req_ready        = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (status.first) begin
               cmd.mul_start = 1'b1;
               cmd.opnd_sel  = OPND_TOTAL;
               state_in      = ST_WAIT_INIT;
            end else begin
               state_in = ST_BODY;
            end
         end
         ST_WAIT_INIT: begin
            if (status.mul_done) begin
               cmd.hash_init = 1'b1;
               state_in      = ST_BODY;
            end
         end
         ST_BODY: begin
            if (status.full) begin
               cmd.mul_start = 1'b1;
               cmd.opnd_sel  = OPND_WORD;
               state_in      = ST_WAIT_W1;
            end else if (status.partial) begin
               cmd.mul_start = 1'b1;
               cmd.opnd_sel  = OPND_HASH_XOR_TAIL;
               state_in      = ST_WAIT_H;
            end else begin
               state_in = ST_FINAL;
            end
         end
         ST_WAIT_W1: begin
            if (status.mul_done) begin
               cmd.mul_start = 1'b1;
               cmd.opnd_sel  = OPND_MIX_PROD;
               state_in      = ST_WAIT_W2;
            end
         end
         ST_WAIT_W2: begin
            if (status.mul_done) begin
               cmd.mul_start = 1'b1;
               cmd.opnd_sel  = OPND_HASH_XOR_PROD;
               state_in      = ST_WAIT_H;
            end
         end
         ST_WAIT_H: begin
            if (status.mul_done) begin
               cmd.hash_update = 1'b1;
               state_in        = ST_FINAL;
            end
         end
         ST_FINAL: begin
            if (!status.last) begin
               state_in = ST_IDLE;
            end else if (status.first && !status.full && !status.partial) begin
               state_in = ST_STORE;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.opnd_sel  = OPND_MIX_HASH;
               state_in      = ST_WAIT_F;
            end
         end
         ST_WAIT_F: begin
            if (status.mul_done) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            if (status.rsp_free) begin
               cmd.result_store = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   // Once a transaction is taken, no other is taken until it is processed.
   a_one_item_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second transaction accepted while one is in progress");
`endif

endmodule

/* rtl/core/murmur2_64_stream_hash_unit.sv */
// ============================================================================
// murmur2_64_stream_hash_unit: streaming 64-bit Murmur2 (shift-mix) hasher
// Takes a message as little-endian 64-bit words and returns one 64-bit hash
// per message on its last word.
// ============================================================================
//
//   Channel   Ports                        Direction  Moves
//   req       req_valid / req_ready        in         one message word
//   rsp       rsp_valid / rsp_ready        out        one finished hash
//   csr       csr_wr_en / csr_wr_data      in         hash seed write
//
// One word is processed at a time. Every multiply by the 64-bit constant runs
// through one shared 32x32 multiplier, and a word takes from none to five of
// them (one for the first word, three for a full word or one for a partial
// word, one for finalization), plus a result store on the last word. A
// finished hash waits in the output register while the next word is taken;
// only a new result stalls on it.
// Reset is synchronous and clears the seed and the running hash to zero.
//
module murmur2_64_stream_hash_unit
   import mh64_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [63:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_data_word,
   input  logic [3:0]  req_valid_bytes,
   input  logic [31:0] req_total_length,
   input  logic        req_first_word,
   input  logic        req_last_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_hash_value
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencing of each transaction.
   mh64_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Hash state, mixing logic and result register.
   mh64_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_data_word    (req_data_word),
      .req_valid_bytes  (req_valid_bytes),
      .req_total_length (req_total_length),
      .req_first_word   (req_first_word),
      .req_last_word    (req_last_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hash_value   (rsp_hash_value)
   );

endmodule

/* tb/sv/murmur2_64_hash_tb_pkg.sv */
// ----------------------------------------------------------------------------
// Murmur2 64-bit hash checker package
// Holds the hash constants and a small scoreboard class. The class keeps its
// own running hash and seed, predicts the finished hash of every message from
// the accepted words, and compares each returned hash against the oldest one.
// ----------------------------------------------------------------------------
package murmur2_64_hash_tb_pkg;

   localparam bit [63:0]   HASH_MUL        = 64'hC6A4A7935BD1E995;
   localparam int unsigned HASH_SHIFT      = 47;
   localparam int unsigned FULL_WORD_BYTES = 8;

   class murmur_hash_predictor;
      bit [63:0]   seed;
      bit [63:0]   running;
      bit [63:0]   hashes_due[$];
      int unsigned mismatches;
      int unsigned hashes_checked;

      // Fold one accepted message word into the running hash, and queue the
      // finished hash when the word closes a message.
      function void absorb_word(bit [63:0] data, bit [3:0] count, bit [31:0] length,
                                bit first_w, bit last_w);
         int unsigned nbytes;
         bit [63:0]   lane;
         nbytes = (count > FULL_WORD_BYTES) ? FULL_WORD_BYTES : count;
         if (first_w) begin
            running = seed ^ (64'(length) * HASH_MUL);
         end
         if (nbytes == FULL_WORD_BYTES) begin
            lane    = data * HASH_MUL;
            lane    = (lane ^ (lane >> HASH_SHIFT)) * HASH_MUL;
            running = (running ^ lane) * HASH_MUL;
         end else if (nbytes != 0) begin
            // A partial word goes in raw, limited to its valid low bytes.
            lane    = data & ((64'd1 << (8 * nbytes)) - 64'd1);
            running = (running ^ lane) * HASH_MUL;
         end
         if (last_w) begin
            if (first_w && nbytes == 0) begin
               // An empty message hashes to zero.
               hashes_due.push_back(64'd0);
            end else begin
               lane = (running ^ (running >> HASH_SHIFT)) * HASH_MUL;
               hashes_due.push_back(lane ^ (lane >> HASH_SHIFT));
            end
         end
      endfunction

      // Compare one returned hash against the oldest outstanding one.
      function void check_hash(logic [63:0] seen);
         bit [63:0] want;
         if (hashes_due.size() == 0) begin
            $error("hash_value: unexpected result, expected none, actual %h", seen);
            mismatches++;
            return;
         end
         want = hashes_due.pop_front();
         hashes_checked++;
         if (seen !== want) begin
            $error("hash_value mismatch: expected %h, actual %h", want, seen);
            mismatches++;
         end
      endfunction
   endclass

endpackage

/* tb/sv/murmur2_64_stream_hash_unit_test.sv */
// ----------------------------------------------------------------------------
// Murmur2 64-bit stream hash unit testbench
// Drives message words into the hash unit under random burst pacing and
// random result back-pressure, predicts every finished hash in a scoreboard,
// and checks each returned hash in order. A short directed list covers the
// corner cases, then random phases run under several seed settings.
// ----------------------------------------------------------------------------
module murmur2_64_stream_hash_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import murmur2_64_hash_tb_pkg::*;

   localparam int unsigned CYCLE_LIMIT     = 1000000;
   localparam int unsigned SETTLE_CYCLES   = 40;
   localparam int unsigned WORDS_PER_PHASE = 376;
   localparam int unsigned SEED_PHASES     = 5;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        csr_wr_en        = 1'b0;
   logic [63:0] csr_wr_data      = '0;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic [63:0] req_data_word    = '0;
   logic [3:0]  req_valid_bytes  = '0;
   logic [31:0] req_total_length = '0;
   logic        req_first_word   = 1'b0;
   logic        req_last_word    = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic [63:0] rsp_hash_value;

   murmur_hash_predictor model;
   int unsigned          words_sent  = 0;
   int unsigned          burst_left  = 4;
   int unsigned          open_left   = 0;
   int unsigned          hold_left   = 0;
   int unsigned          cycle_count = 0;

   murmur2_64_stream_hash_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_word    (req_data_word),
      .req_valid_bytes  (req_valid_bytes),
      .req_total_length (req_total_length),
      .req_first_word   (req_first_word),
      .req_last_word    (req_last_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hash_value   (rsp_hash_value)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Present one word and hold it until the transaction completes, then apply
   // the burst pacing. Ready is sampled at the falling edge, so the transaction
   // lands on the following rising edge.
   task automatic send_word(bit [63:0] data, bit [3:0] count, bit [31:0] length,
                            bit first_w, bit last_w);
      req_valid        <= 1'b1;
      req_data_word    <= data;
      req_valid_bytes  <= count;
      req_total_length <= length;
      req_first_word   <= first_w;
      req_last_word    <= last_w;
      @(negedge clock);
      while (req_ready !== 1'b1) @(negedge clock);
      @(posedge clock);
      model.absorb_word(data, count, length, first_w, last_w);
      words_sent++;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 28)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                  : $urandom_range(1, 8);
      end else begin
         burst_left--;
      end
   endtask

   // Stop sending, wait for every outstanding hash, then let any word that
   // produces no result finish inside the unit.
   task automatic settle();
      req_valid <= 1'b0;
      while (model.hashes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Result side back-pressure: open stretches and stalls of random length.
   always @(posedge clock) begin
      if (open_left != 0) begin
         rsp_ready <= 1'b1;
         open_left--;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= 1'b0;
         open_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 300)
                                                 : $urandom_range(1, 12);
         hold_left = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(1, 4);
      end
   end

   // A result transaction completes on the rising edge after this sample.
   always @(negedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         model.check_hash(rsp_hash_value);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      bit [63:0]   seeds[SEED_PHASES];
      int unsigned pick;
      int unsigned len;
      int unsigned nwords;
      int unsigned phase_start;
      bit [31:0]   length;
      bit          with_first;
      bit          with_last;

      model = new();
      seeds[0] = 64'hFFFF_FFFF_FFFF_FFFF;
      seeds[1] = 64'h0;
      seeds[2] = {$urandom, $urandom};
      seeds[3] = 64'h1;
      seeds[4] = {$urandom, $urandom};

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed corner cases under the reset seed.
      // An empty message gives zero.
      send_word({$urandom, $urandom}, 4'd0, 32'd0, 1'b1, 1'b1);
      // Single partial words with every data bit set, so the byte mask matters.
      send_word('1, 4'd1, 32'd1, 1'b1, 1'b1);
      send_word('1, 4'd7, 32'd7, 1'b1, 1'b1);
      // Single full words at the data and length extremes.
      send_word('1, 4'd8, 32'd8, 1'b1, 1'b1);
      send_word('0, 4'd8, 32'hFFFF_FFFF, 1'b1, 1'b1);
      // Byte counts above eight behave as a full word.
      send_word(64'h0123_4567_89AB_CDEF, 4'd15, 32'd8, 1'b1, 1'b1);
      send_word(64'hFEDC_BA98_7654_3210, 4'd9, 32'd8, 1'b1, 1'b1);
      // Three-word message ending in a partial word.
      send_word(64'h8000_0000_0000_0001, 4'd8, 32'd19, 1'b1, 1'b0);
      send_word(64'h5555_AAAA_5555_AAAA, 4'd8, 32'd19, 1'b0, 1'b0);
      send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd3, 32'd19, 1'b0, 1'b1);
      // A partial word ahead of the last word.
      send_word(64'h0000_00A5_A5A5_A5A5, 4'd5, 32'd13, 1'b1, 1'b0);
      send_word(64'hDEAD_BEEF_0BAD_F00D, 4'd8, 32'd13, 1'b0, 1'b1);
      // Zero-byte words inside and at the end of a message; it still finalizes.
      send_word(64'h1111_2222_3333_4444, 4'd8, 32'd8, 1'b1, 1'b0);
      send_word('1, 4'd0, 32'd8, 1'b0, 1'b0);
      send_word('1, 4'd0, 32'd8, 1'b0, 1'b1);
      // A first word with no bytes only loads the initial hash.
      send_word('1, 4'd0, 32'h8000_0000, 1'b1, 1'b0);
      send_word(64'h0000_0000_0000_BEEF, 4'd2, 32'd2, 1'b0, 1'b1);
      // Words with no first word carry on from the running hash.
      send_word(64'h7777_7777_7777_7777, 4'd8, 32'd0, 1'b0, 1'b0);
      send_word(64'h0000_0000_CAFE_BABE, 4'd4, 32'd0, 1'b0, 1'b1);
      // An empty message with a nonzero length still gives zero.
      send_word('1, 4'd0, 32'hFFFF_FFFF, 1'b1, 1'b1);
      settle();

      // Random phases, each under its own seed written while the unit is idle.
      for (int p = 0; p < SEED_PHASES; p++) begin
         csr_wr_en   <= 1'b1;
         csr_wr_data <= seeds[p];
         @(posedge clock);
         csr_wr_en   <= 1'b0;
         model.seed = seeds[p];
         phase_start = words_sent;
         while (words_sent - phase_start < WORDS_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            if (pick < 88) begin
               // Mostly well-formed messages; a few lose their first or last flag.
               case ($urandom_range(0, 9))
                  0:       len = 0;
                  7, 8:    len = $urandom_range(33, 100);
                  9:       len = $urandom_range(101, 256);
                  default: len = $urandom_range(1, 32);
               endcase
               length     = ($urandom_range(0, 9) == 0) ? $urandom : len;
               with_first = !(pick >= 80 && pick < 84);
               with_last  = (pick < 84);
               nwords     = (len == 0) ? 1 : (len + 7) / 8;
               for (int i = 0; i < nwords; i++) begin
                  send_word({$urandom, $urandom},
                            (i == nwords - 1) ? 4'(len - 8 * i) : 4'd8,
                            length, with_first && i == 0, with_last && i == nwords - 1);
               end
            end else begin
               // Noise: every field random, including byte counts above eight.
               send_word({$urandom, $urandom}, 4'($urandom_range(0, 15)), $urandom,
                         $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
            end
         end
         settle();
      end

      $display("Sent %0d message words and checked %0d hashes across %0d seed settings,",
               words_sent, model.hashes_checked, SEED_PHASES + 1);
      $display("including empty, partial, oversized-count and headless messages.");
      if (model.mismatches == 0 && model.hashes_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
